/* sv/agfd_pkg.sv */
// ----------------------------------------------------------------------------
// agfd_pkg
// types, constants and the radius table shared by the alert field decoder
// ----------------------------------------------------------------------------
package agfd_pkg;

	// field kinds
	localparam logic [3:0] KIND_LAT16     = 4'd0;
	localparam logic [3:0] KIND_LON17     = 4'd1;
	localparam logic [3:0] KIND_LAT17     = 4'd2;
	localparam logic [3:0] KIND_LON45     = 4'd3;
	localparam logic [3:0] KIND_RADIUS    = 4'd4;
	localparam logic [3:0] KIND_AZ6       = 4'd5;
	localparam logic [3:0] KIND_AZ7       = 4'd6;
	localparam logic [3:0] KIND_B1LAT     = 4'd7;
	localparam logic [3:0] KIND_B1LON     = 4'd8;
	localparam logic [3:0] KIND_REFRADIUS = 4'd9;
	localparam logic [3:0] KIND_B2DELTA   = 4'd10;

	// multiplier constants
	localparam logic signed [29:0] LAT_SPAN   = 30'sd180000000;
	localparam logic signed [29:0] LON_SPAN   = 30'sd360000000;
	localparam logic signed [29:0] AZ_SPAN    = 30'sd18000000;
	localparam logic signed [29:0] DELTA_STEP = 30'sd156250;

	// rounding terms added after the product
	localparam logic [19:0] HALF_16    = 20'd32767;
	localparam logic [19:0] HALF_17    = 20'd65535;
	localparam logic [19:0] HALF_AZ6   = 20'd32;
	localparam logic [19:0] HALF_AZ7   = 20'd64;
	localparam logic [19:0] HALF_B1LAT = 20'd262140;
	localparam logic [19:0] HALF_B1LON = 20'd524284;
	localparam logic [19:0] REF_ROUND     = 20'd4;
	localparam logic [19:0] REF_ROUND_NEG = 20'd11;

	// result offsets
	localparam logic signed [31:0] LAT_OFF   = -32'sd90000000;
	localparam logic signed [31:0] LON_OFF   = -32'sd180000000;
	localparam logic signed [31:0] LON45_OFF = 32'sd45000000;
	localparam logic signed [31:0] AZ_OFF    = -32'sd9000000;
	localparam logic signed [31:0] DELTA_OFF = -32'sd10000000;

	// divisors of the form 2^k - 1
	localparam logic [17:0] DIV_16 = 18'd65535;
	localparam logic [17:0] DIV_17 = 18'd131071;

	localparam int RADIUS_ENTRIES = 32;

	localparam logic [21:0] RADIUS_TBL [RADIUS_ENTRIES] = '{
		22'd216,     22'd292,     22'd395,     22'd535,
		22'd723,     22'd978,     22'd1322,    22'd1788,
		22'd2418,    22'd3269,    22'd4421,    22'd5979,
		22'd8085,    22'd10933,   22'd14784,   22'd19992,
		22'd27035,   22'd36559,   22'd49439,   22'd66855,
		22'd90407,   22'd122255,  22'd165324,  22'd223564,
		22'd302322,  22'd408824,  22'd552846,  22'd747603,
		22'd1010970, 22'd1367116, 22'd1848727, 22'd2500000
	};

	// how the final value is formed from the quotient stage
	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_SUB   = 2'd1,
		OP_DIV16 = 2'd2,
		OP_DIV17 = 2'd3
	} op_t;

	// per-item operands for the shared multiplier and the later stages
	typedef struct packed {
		logic signed [29:0] mul_a;
		logic [16:0]        mul_b;
		logic [19:0]        add_h;
		logic [2:0]         shift;
		op_t                op;
		logic signed [31:0] offset;
		logic               bad;
	} operand_t;

endpackage

/* sv/alert_geo_field_decoder.sv */
// an item passes four registers: input, product, quotient estimate, result
// throughput: one item per cycle while result_stall is low;
// every stage advances on its own valid and stall
// reset: arst_n clears every stage valid bit at once, payload registers are not reset
// nothing else is held between items, so the block is ready right after reset
// ----------------------------------------------------------------------------
// alert_geo_field_decoder
// decodes one raw alert message field per item into a signed value by kind
// ----------------------------------------------------------------------------
module alert_geo_field_decoder (
	input  logic               clk,
	input  logic               arst_n,
	// input items
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [3:0]         kind,
	input  logic [16:0]        code,
	input  logic [21:0]        base_radius,
	input  logic [7:0]         orig_radius_code,
	// result items
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] value,
	output logic               bad_kind
);

	// stage valid bits and the ready chain back from the result register
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4 = !v_s4 || !result_stall;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign item_stall   = !rdy_s1;
	assign result_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: input register
	logic [3:0]  kind_s1;
	logic [16:0] code_s1;
	logic [21:0] base_s1;
	logic [7:0]  orig_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && item_valid) begin
			kind_s1 <= kind;
			code_s1 <= code;
			base_s1 <= base_radius;
			orig_s1 <= orig_radius_code;
		end
	end

	// per-kind operands, then the one multiplier with rounding term and shift
	agfd_pkg::operand_t opnd;

	agfd_operand u_operand (
		.kind             (kind_s1),
		.code             (code_s1),
		.base_radius      (base_s1),
		.orig_radius_code (orig_s1),
		.opnd             (opnd)
	);

	logic signed [47:0] mul_a_ext;
	logic signed [47:0] mul_b_ext;
	logic signed [47:0] prod;
	logic signed [47:0] prod_rnd;
	logic signed [47:0] n_nxt;

	always_comb begin
		mul_a_ext = 48'(opnd.mul_a);
		mul_b_ext = $signed({31'b0, opnd.mul_b});
		prod      = mul_a_ext * mul_b_ext;
		prod_rnd  = prod + $signed({28'b0, opnd.add_h});
		// arithmetic shift, which truncates the refined radius term toward zero
		// thanks to the adjusted rounding term
		n_nxt     = prod_rnd >>> opnd.shift;
	end

	// stage 2: scaled numerator
	logic signed [47:0] n_s2;
	agfd_pkg::op_t      op_s2;
	logic signed [31:0] off_s2;
	logic               bad_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			n_s2   <= n_nxt;
			op_s2  <= opnd.op;
			off_s2 <= opnd.offset;
			bad_s2 <= opnd.bad;
		end
	end

	// quotient estimate for a divide by 2^k - 1:
	// (n + n/2^k + n/2^2k) / 2^k, never above the true quotient, at most one below
	logic        k17_s2;
	logic        div_s2;
	logic [45:0] dn;
	logic [46:0] dsum;
	logic [31:0] q_est;
	logic [31:0] q_nxt;

	always_comb begin
		k17_s2 = (op_s2 == agfd_pkg::OP_DIV17);
		div_s2 = (op_s2 == agfd_pkg::OP_DIV16) || (op_s2 == agfd_pkg::OP_DIV17);
		dn     = n_s2[45:0];
		dsum   = {1'b0, dn} + 47'(k17_s2 ? (dn >> 17) : (dn >> 16))
			+ 47'(k17_s2 ? (dn >> 34) : (dn >> 32));
		q_est  = k17_s2 ? 32'(dsum[46:17]) : 32'(dsum[46:16]);
		q_nxt  = div_s2 ? q_est : n_s2[31:0];
	end

	// stage 3: quotient estimate, numerator kept for the remainder check
	logic [45:0]        n_s3;
	logic signed [31:0] q_s3;
	agfd_pkg::op_t      op_s3;
	logic signed [31:0] off_s3;
	logic               bad_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			n_s3   <= dn;
			q_s3   <= $signed(q_nxt);
			op_s3  <= op_s2;
			off_s3 <= off_s2;
			bad_s3 <= bad_s2;
		end
	end

	// remainder = n - q * (2^k - 1), done with a shift and a subtract
	logic               k17_s3;
	logic [17:0]        div_d;
	logic [47:0]        qd;
	logic [47:0]        rem;
	logic               corr;
	logic signed [31:0] value_nxt;

	always_comb begin
		k17_s3 = (op_s3 == agfd_pkg::OP_DIV17);
		div_d  = k17_s3 ? agfd_pkg::DIV_17 : agfd_pkg::DIV_16;
		qd     = k17_s3 ? ((48'(q_s3) << 17) - 48'(q_s3))
			: ((48'(q_s3) << 16) - 48'(q_s3));
		rem    = 48'(n_s3) - qd;
		corr   = (rem >= 48'(div_d));
		case (op_s3)
			agfd_pkg::OP_ADD:   value_nxt = off_s3 + q_s3;
			agfd_pkg::OP_SUB:   value_nxt = off_s3 - q_s3;
			agfd_pkg::OP_DIV16,
			agfd_pkg::OP_DIV17: value_nxt = off_s3 + q_s3 + $signed({31'b0, corr});
			default:            value_nxt = '0;
		endcase
	end

	// stage 4: result register
	logic signed [31:0] value_s4;
	logic               bad_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			value_s4 <= value_nxt;
			bad_s4   <= bad_s3;
		end
	end

	assign value    = value_s4;
	assign bad_kind = bad_s4;

`ifndef ASSERT_OFF
	// a reserved kind always comes out as zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_kind |-> value == 32'sd0)
		else $error("reserved kind gave a non-zero value");

	// the quotient estimate is exact or one low, so the remainder stays below 2d
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (op_s3 == agfd_pkg::OP_DIV16 || op_s3 == agfd_pkg::OP_DIV17)
		|-> rem < (48'(div_d) << 1))
		else $error("quotient estimate out of range");

	// the input side only stalls when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> v_s1 && v_s2 && v_s3 && v_s4)
		else $error("input stalled with a free stage");

	// with the result side flowing, the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> !item_stall)
		else $error("input stalled while results drain");
`endif

endmodule

/* sv/agfd_operand.sv */
// ----------------------------------------------------------------------------
// agfd_operand
// per-kind operand selection: multiplier inputs, rounding term, shift,
// final operation and offset, including the radius table lookups
// ----------------------------------------------------------------------------
module agfd_operand (
	input  logic [3:0]         kind,
	input  logic [16:0]        code,
	input  logic [21:0]        base_radius,
	input  logic [7:0]         orig_radius_code,
	output agfd_pkg::operand_t opnd
);

	logic [7:0]         c8;
	logic [7:0]         orig_m1;
	logic [21:0]        rad_code;
	logic [21:0]        rad_orig;
	logic [21:0]        rad_prev;
	logic signed [22:0] step;

	assign c8      = code[7:0];
	assign orig_m1 = orig_radius_code - 8'd1;

	always_comb begin
		rad_code = (c8 < 8'd32) ? agfd_pkg::RADIUS_TBL[c8[4:0]] : '0;
		rad_orig = (orig_radius_code < 8'd32) ?
			agfd_pkg::RADIUS_TBL[orig_radius_code[4:0]] : '0;
		rad_prev = (orig_m1 < 8'd32) ? agfd_pkg::RADIUS_TBL[orig_m1[4:0]] : '0;
		if (orig_radius_code == 8'd0) begin
			step = $signed({1'b0, agfd_pkg::RADIUS_TBL[0]});
		end else begin
			step = $signed({1'b0, rad_orig}) - $signed({1'b0, rad_prev});
		end
	end

	always_comb begin
		opnd.mul_a  = '0;
		opnd.mul_b  = '0;
		opnd.add_h  = '0;
		opnd.shift  = 3'd0;
		opnd.op     = agfd_pkg::OP_ADD;
		opnd.offset = '0;
		opnd.bad    = 1'b0;
		case (kind)
			agfd_pkg::KIND_LAT16: begin
				opnd.mul_a  = agfd_pkg::LAT_SPAN;
				opnd.mul_b  = {1'b0, code[15:0]};
				opnd.add_h  = agfd_pkg::HALF_16;
				opnd.op     = agfd_pkg::OP_DIV16;
				opnd.offset = agfd_pkg::LAT_OFF;
			end
			agfd_pkg::KIND_LON17: begin
				opnd.mul_a  = agfd_pkg::LON_SPAN;
				opnd.mul_b  = code;
				opnd.add_h  = agfd_pkg::HALF_17;
				opnd.op     = agfd_pkg::OP_DIV17;
				opnd.offset = agfd_pkg::LON_OFF;
			end
			agfd_pkg::KIND_LAT17: begin
				opnd.mul_a  = agfd_pkg::LAT_SPAN;
				opnd.mul_b  = code;
				opnd.add_h  = agfd_pkg::HALF_17;
				opnd.op     = agfd_pkg::OP_DIV17;
				opnd.offset = agfd_pkg::LAT_OFF;
			end
			agfd_pkg::KIND_LON45: begin
				opnd.mul_a  = agfd_pkg::LAT_SPAN;
				opnd.mul_b  = code;
				opnd.add_h  = agfd_pkg::HALF_17;
				opnd.op     = agfd_pkg::OP_DIV17;
				opnd.offset = agfd_pkg::LON45_OFF;
			end
			agfd_pkg::KIND_RADIUS: begin
				opnd.offset = $signed({10'b0, rad_code});
			end
			agfd_pkg::KIND_AZ6: begin
				opnd.mul_a  = agfd_pkg::AZ_SPAN;
				opnd.mul_b  = {9'b0, c8};
				opnd.add_h  = agfd_pkg::HALF_AZ6;
				opnd.shift  = 3'd6;
				opnd.offset = agfd_pkg::AZ_OFF;
			end
			agfd_pkg::KIND_AZ7: begin
				opnd.mul_a  = agfd_pkg::AZ_SPAN;
				opnd.mul_b  = {9'b0, c8};
				opnd.add_h  = agfd_pkg::HALF_AZ7;
				opnd.shift  = 3'd7;
				opnd.offset = agfd_pkg::AZ_OFF;
			end
			agfd_pkg::KIND_B1LAT: begin
				// divisor is 8 * (2^16 - 1): drop three bits first
				opnd.mul_a  = agfd_pkg::LAT_SPAN;
				opnd.mul_b  = {9'b0, c8};
				opnd.add_h  = agfd_pkg::HALF_B1LAT;
				opnd.shift  = 3'd3;
				opnd.op     = agfd_pkg::OP_DIV16;
			end
			agfd_pkg::KIND_B1LON: begin
				opnd.mul_a  = agfd_pkg::LON_SPAN;
				opnd.mul_b  = {9'b0, c8};
				opnd.add_h  = agfd_pkg::HALF_B1LON;
				opnd.shift  = 3'd3;
				opnd.op     = agfd_pkg::OP_DIV17;
			end
			agfd_pkg::KIND_REFRADIUS: begin
				// truncating divide by 8: a negative product gets seven more
				opnd.mul_a  = 30'(step);
				opnd.mul_b  = {9'b0, c8};
				opnd.add_h  = (step < 0 && c8 != 8'd0) ?
					agfd_pkg::REF_ROUND_NEG : agfd_pkg::REF_ROUND;
				opnd.shift  = 3'd3;
				opnd.op     = agfd_pkg::OP_SUB;
				opnd.offset = $signed({10'b0, base_radius});
			end
			agfd_pkg::KIND_B2DELTA: begin
				// the zero value is skipped: codes from 64 upwards count one step higher
				opnd.mul_a  = agfd_pkg::DELTA_STEP;
				opnd.mul_b  = (c8 >= 8'd64) ? 17'(c8) + 17'd1 : 17'(c8);
				opnd.offset = agfd_pkg::DELTA_OFF;
			end
			default: begin
				opnd.bad = 1'b1;
			end
		endcase
	end

endmodule

/* bench/agfd_field_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// agfd_field_checker
// watches both channels of the alert field decoder, works out each decoded
// field on its own and compares it with the result items in order
// ----------------------------------------------------------------------------
module agfd_field_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [3:0]         kind,
	input  logic [16:0]        code,
	input  logic [21:0]        base_radius,
	input  logic [7:0]         orig_radius_code,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic signed [31:0] value,
	input  logic               bad_kind,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [31:0] value;
		logic               bad_kind;
	} decoded_t;

	// log radius steps in metres
	longint radius_tbl [0:31] = '{
		216, 292, 395, 535, 723, 978, 1322, 1788,
		2418, 3269, 4421, 5979, 8085, 10933, 14784, 19992,
		27035, 36559, 49439, 66855, 90407, 122255, 165324, 223564,
		302322, 408824, 552846, 747603, 1010970, 1367116, 1848727, 2500000
	};

	decoded_t decodes_due [$];

	function automatic longint radius_m(input logic [7:0] idx);
		return (idx < 8'd32) ? radius_tbl[idx[4:0]] : 64'sd0;
	endfunction

	function automatic decoded_t decode_field(input logic [3:0] k, input logic [16:0] c,
			input logic [21:0] b, input logic [7:0] o);
		longint unsigned c17;
		longint unsigned c16;
		longint unsigned c8;
		longint          v;
		longint          step;
		decoded_t        d;
		c17 = 64'(c);
		c16 = 64'(c[15:0]);
		c8 = 64'(c[7:0]);
		v = 0;
		d.kind = k;
		d.bad_kind = 1'b0;
		case (k)
		agfd_pkg::KIND_LAT16:
			v = -64'sd90000000 + longint'((64'd180000000 * c16 + 64'd32767) / 64'd65535);
		agfd_pkg::KIND_LON17:
			v = -64'sd180000000 + longint'((64'd360000000 * c17 + 64'd65535) / 64'd131071);
		agfd_pkg::KIND_LAT17:
			v = -64'sd90000000 + longint'((64'd180000000 * c17 + 64'd65535) / 64'd131071);
		agfd_pkg::KIND_LON45:
			v = 64'sd45000000 + longint'((64'd180000000 * c17 + 64'd65535) / 64'd131071);
		agfd_pkg::KIND_RADIUS:
			v = radius_m(c[7:0]);
		agfd_pkg::KIND_AZ6:
			v = -64'sd9000000 + longint'((64'd18000000 * c8 + 64'd32) / 64'd64);
		agfd_pkg::KIND_AZ7:
			v = -64'sd9000000 + longint'((64'd18000000 * c8 + 64'd64) / 64'd128);
		agfd_pkg::KIND_B1LAT:
			v = longint'((c8 * 64'd180000000 + 64'd262140) / 64'd524280);
		agfd_pkg::KIND_B1LON:
			v = longint'((c8 * 64'd360000000 + 64'd524284) / 64'd1048568);
		agfd_pkg::KIND_REFRADIUS: begin
			// step from the original code, negative at code 32, zero above it
			step = (o == 8'd0) ? radius_tbl[0] : radius_m(o) - radius_m(o - 8'd1);
			v = longint'(b) - (step * longint'(c8) + 64'sd4) / 64'sd8;
		end
		agfd_pkg::KIND_B2DELTA:
			v = -64'sd10000000
				+ 64'sd156250 * (longint'(c8) + ((c8 >= 64) ? 64'sd1 : 64'sd0));
		default:
			d.bad_kind = 1'b1;
		endcase
		d.value = v[31:0];
		return d;
	endfunction

	always @(posedge clk) begin
		decoded_t want;
		if (!arst_n) begin
			decodes_due.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (item_valid && !item_stall)
				decodes_due.push_back(decode_field(kind, code, base_radius, orig_radius_code));
			if (result_valid && !result_stall) begin
				if (decodes_due.size() == 0) begin
					$display("%0t: result with none due, expected nothing, actual %0d %0b",
						$time, value, bad_kind);
					mismatches <= mismatches + 1;
				end else begin
					want = decodes_due.pop_front();
					if (value !== want.value || bad_kind !== want.bad_kind) begin
						$display("%0t: kind %0d, expected %0d %0b, actual %0d %0b",
							$time, want.kind, want.value, want.bad_kind, value, bad_kind);
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= decodes_due.size();
		end
	end

endmodule

/* bench/tb_alert_geo_field_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alert_geo_field_decoder
// drives alert message fields into the decoder in bursts, first the corner
// codes of every kind then random fields, while the result side stalls on a
// changing pattern; the checker beside the block judges every result
// ----------------------------------------------------------------------------
module tb_alert_geo_field_decoder;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 10;
	localparam int RANDOM_ITEMS   = 400;
	localparam int TAIL_CYCLES    = 16;
	// far above the longest quiet stretch of a correct run
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [3:0]  KIND_RSVD_LO = agfd_pkg::KIND_B2DELTA + 4'd1;
	localparam logic [3:0]  KIND_RSVD_HI = 4'hF;
	localparam logic [16:0] CODE_MAX     = 17'h1FFFF;
	localparam logic [21:0] BASE_MAX     = 22'h3FFFFF;

	// how the result side holds off
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_TEETH,
		STALL_HEAVY
	} stall_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic [3:0]         kind;
	logic [16:0]        code;
	logic [21:0]        base_radius;
	logic [7:0]         orig_radius_code;
	logic               result_valid;
	logic               result_stall;
	logic signed [31:0] value;
	logic               bad_kind;

	int                 mismatches;
	int                 outstanding;
	int                 quiet_cycles = 0;
	logic [5:0]         stall_tick = '0;
	stall_mode_t        stall_mode = STALL_NONE;

	always #(CLK_PERIOD / 2) clk = ~clk;

	alert_geo_field_decoder DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.kind             (kind),
		.code             (code),
		.base_radius      (base_radius),
		.orig_radius_code (orig_radius_code),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.value            (value),
		.bad_kind         (bad_kind)
	);

	agfd_field_checker field_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.kind             (kind),
		.code             (code),
		.base_radius      (base_radius),
		.orig_radius_code (orig_radius_code),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.value            (value),
		.bad_kind         (bad_kind),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	// result side: a random stall mode is drawn when the tick counter wraps, teeth follow its low bits
	always @(posedge clk) begin
		stall_tick <= stall_tick + 6'd1;
		if (stall_tick == '1)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
		STALL_NONE:  result_stall <= 1'b0;
		STALL_COIN:  result_stall <= ($urandom_range(0, 1) == 0);
		STALL_TEETH: result_stall <= (stall_tick[2:0] >= 3'd5);
		default:     result_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// watchdog: quiet cycles on both channels end the run
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_alert_geo_field_decoder NOT OK");
			$finish;
		end
	end

	// present one item and hold it until the block takes it; valid stays high after
	task automatic send_field(input logic [3:0] k, input logic [16:0] c,
			input logic [21:0] b, input logic [7:0] o);
		item_valid <= 1'b1;
		kind <= k;
		code <= c;
		base_radius <= b;
		orig_radius_code <= o;
		do @(posedge clk); while (item_stall);
	endtask

	// lower valid and wait until every result due has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int          sent;
		int          burst;
		int          gap;
		bit          paused;
		logic [3:0]  k;
		logic [16:0] c;
		logic [21:0] b;
		logic [7:0]  o;

		sent = 0;
		paused = 1'b0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		kind <= '0;
		code <= '0;
		base_radius <= '0;
		orig_radius_code <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners of each kind, back to back
		send_field(agfd_pkg::KIND_LAT16, 17'd0, '0, '0);
		send_field(agfd_pkg::KIND_LAT16, 17'h0FFFF, '0, '0);
		// bit 16 must be dropped for the 16-bit latitude
		send_field(agfd_pkg::KIND_LAT16, CODE_MAX, '0, '0);
		send_field(agfd_pkg::KIND_LON17, 17'd0, '0, '0);
		send_field(agfd_pkg::KIND_LON17, CODE_MAX, '0, '0);
		send_field(agfd_pkg::KIND_LAT17, CODE_MAX, '0, '0);
		send_field(agfd_pkg::KIND_LON45, CODE_MAX, '0, '0);
		// radius table ends and codes past it
		send_field(agfd_pkg::KIND_RADIUS, 17'd0, '0, '0);
		send_field(agfd_pkg::KIND_RADIUS, 17'd31, '0, '0);
		send_field(agfd_pkg::KIND_RADIUS, 17'd32, '0, '0);
		send_field(agfd_pkg::KIND_RADIUS, CODE_MAX, '0, '0);
		// byte kinds above their nominal width
		send_field(agfd_pkg::KIND_AZ6, 17'd255, '0, '0);
		send_field(agfd_pkg::KIND_AZ7, 17'd255, '0, '0);
		send_field(agfd_pkg::KIND_B1LAT, 17'd255, '0, '0);
		send_field(agfd_pkg::KIND_B1LON, 17'd255, '0, '0);
		// refinement: first step, last step, negative step, zero step
		send_field(agfd_pkg::KIND_REFRADIUS, 17'd255, BASE_MAX, 8'd0);
		send_field(agfd_pkg::KIND_REFRADIUS, 17'd255, '0, 8'd31);
		send_field(agfd_pkg::KIND_REFRADIUS, 17'd255, '0, 8'd32);
		send_field(agfd_pkg::KIND_REFRADIUS, 17'd255, BASE_MAX, 8'd33);
		send_field(agfd_pkg::KIND_REFRADIUS, 17'd7, 22'd1000, 8'd255);
		// hazard delta either side of the skipped zero
		send_field(agfd_pkg::KIND_B2DELTA, 17'd63, '0, '0);
		send_field(agfd_pkg::KIND_B2DELTA, 17'd64, '0, '0);
		send_field(agfd_pkg::KIND_B2DELTA, CODE_MAX, '0, '0);
		send_field(KIND_RSVD_LO, CODE_MAX, BASE_MAX, 8'hFF);
		send_field(KIND_RSVD_HI, 17'd0, '0, '0);
		drain_results();

		// random fields in bursts; reserved kinds now and then
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				k = ($urandom_range(0, 9) == 0)
					? 4'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI))
					: 4'($urandom_range(agfd_pkg::KIND_LAT16, agfd_pkg::KIND_B2DELTA));
				c = 17'($urandom_range(0, CODE_MAX));
				// table kinds get a code from 0 to 40 half of the time
				if ((k == agfd_pkg::KIND_RADIUS || k == agfd_pkg::KIND_REFRADIUS)
						&& $urandom_range(0, 1) == 0)
					c = 17'($urandom_range(0, 40));
				case ($urandom_range(0, 7))
				0:       b = '0;
				1:       b = BASE_MAX;
				default: b = 22'($urandom_range(0, BASE_MAX));
				endcase
				o = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 34))
					: 8'($urandom_range(0, 255));
				send_field(k, c, b, o);
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				// hold the sender until the pipeline is empty once
				drain_results();
				paused = 1'b1;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				// no gap keeps valid high straight into the next burst
				if (gap > 0) begin
					item_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_alert_geo_field_decoder OK");
		else
			$display("tb_alert_geo_field_decoder NOT OK");
		$finish;
	end

endmodule

/* alert_geo_field_decoder.f */
sv/agfd_pkg.sv
sv/agfd_operand.sv
sv/alert_geo_field_decoder.sv
bench/agfd_field_checker.sv
bench/tb_alert_geo_field_decoder.sv
